// File: hdl/bfie_pkg.sv
// Shared types and constants of the Brainfuck instruction executor.
`default_nettype none

package bfie_pkg;

   // Program bytes that are commands.
   localparam logic [7:0] OP_LEFT  = 8'h3C;
   localparam logic [7:0] OP_RIGHT = 8'h3E;
   localparam logic [7:0] OP_INC   = 8'h2B;
   localparam logic [7:0] OP_DEC   = 8'h2D;
   localparam logic [7:0] OP_OPEN  = 8'h5B;
   localparam logic [7:0] OP_CLOSE = 8'h5D;
   localparam logic [7:0] OP_OUT   = 8'h2E;
   localparam logic [7:0] OP_IN    = 8'h2C;

   // Input byte that stores all ones.
   localparam logic [7:0] TILDE_BYTE = 8'h7E;

   localparam int SKIP_WIDTH = 16;
   localparam int FIFO_DEPTH = 4;

   typedef enum logic [3:0] {
      CMD_NOP,
      CMD_LEFT,
      CMD_RIGHT,
      CMD_INC,
      CMD_DEC,
      CMD_OPEN,
      CMD_CLOSE,
      CMD_OUT,
      CMD_IN
   } cmd_type;

   typedef enum logic [2:0] {
      KIND_NONE  = 3'd0,
      KIND_CHAR  = 3'd1,
      KIND_EOF   = 3'd2,
      KIND_JUMP  = 3'd3,
      KIND_ERROR = 3'd4
   } kind_type;

   // Control from the execution side back to the decode queue.
   typedef struct packed {
      logic pop;
      logic clearing;
   } back_ctrl_type;

endpackage

`default_nettype wire

// File: hdl/bfie_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module bfie_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  wire logic                                    clock,
   input  wire logic                                    wr_en,
   input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                        wr_data,
   input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic      [WIDTH-1:0]                        rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

`default_nettype wire

// File: hdl/bfie_front.sv
// Front end: classifies program bytes and queues decoded commands.
`default_nettype none

module bfie_front #(
   parameter int POSITION_WIDTH = 16,
   parameter int CELL_WIDTH     = 32
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire logic [7:0]                    req_op,
   input  wire logic [POSITION_WIDTH-1:0]     req_next_position,
   input  wire logic [7:0]                    req_in_byte,
   input  wire bfie_pkg::back_ctrl_type       ctrl,
   output logic                               q_valid,
   output bfie_pkg::cmd_type                  q_cmd,
   output logic [POSITION_WIDTH-1:0]          q_pos,
   output logic [CELL_WIDTH-1:0]              q_value
);
   import bfie_pkg::*;

   localparam int QA_W = $clog2(FIFO_DEPTH);
   localparam int QC_W = $clog2(FIFO_DEPTH + 1);

   cmd_type                   cmd_mem [FIFO_DEPTH];
   logic [POSITION_WIDTH-1:0] pos_mem [FIFO_DEPTH];
   logic [CELL_WIDTH-1:0]     val_mem [FIFO_DEPTH];

   logic [QA_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QA_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QC_W-1:0] count_ff, count_in;

   cmd_type               dec_cmd;
   logic [CELL_WIDTH-1:0] dec_value;
   logic                  push;

   always_comb begin
      case (req_op)
         OP_LEFT:  dec_cmd = CMD_LEFT;
         OP_RIGHT: dec_cmd = CMD_RIGHT;
         OP_INC:   dec_cmd = CMD_INC;
         OP_DEC:   dec_cmd = CMD_DEC;
         OP_OPEN:  dec_cmd = CMD_OPEN;
         OP_CLOSE: dec_cmd = CMD_CLOSE;
         OP_OUT:   dec_cmd = CMD_OUT;
         OP_IN:    dec_cmd = CMD_IN;
         default:  dec_cmd = CMD_NOP;
      endcase
      // A tilde reads as end of input and stores all ones.
      if (req_in_byte == TILDE_BYTE) begin
         dec_value = '1;
      end else begin
         dec_value = CELL_WIDTH'($signed(req_in_byte));
      end
   end

   assign req_stall = ctrl.clearing || (count_ff == QC_W'(FIFO_DEPTH));
   assign push      = req_valid && !req_stall;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push) begin
         wr_ptr_in = wr_ptr_ff + 1'b1;
      end
      if (ctrl.pop) begin
         rd_ptr_in = rd_ptr_ff + 1'b1;
      end
      count_in = count_ff + QC_W'(push) - QC_W'(ctrl.pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         cmd_mem[wr_ptr_ff] <= dec_cmd;
         pos_mem[wr_ptr_ff] <= req_next_position;
         val_mem[wr_ptr_ff] <= dec_value;
      end
   end

   assign q_valid = (count_ff != '0);
   assign q_cmd   = cmd_mem[rd_ptr_ff];
   assign q_pos   = pos_mem[rd_ptr_ff];
   assign q_value = val_mem[rd_ptr_ff];

endmodule

`default_nettype wire

// File: hdl/bfie_back.sv
// Back end: executes decoded commands against the tape and the loop stack.
`default_nettype none

module bfie_back #(
   parameter int TAPE_DEPTH     = 32768,
   parameter int STACK_DEPTH    = 64,
   parameter int POSITION_WIDTH = 16,
   parameter int CELL_WIDTH     = 32
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          q_valid,
   input  wire bfie_pkg::cmd_type             q_cmd,
   input  wire logic [POSITION_WIDTH-1:0]     q_pos,
   input  wire logic [CELL_WIDTH-1:0]         q_value,
   output bfie_pkg::back_ctrl_type            ctrl,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output bfie_pkg::kind_type                 rsp_kind,
   output logic [7:0]                         rsp_out_char,
   output logic [POSITION_WIDTH-1:0]          rsp_jump_target
);
   import bfie_pkg::*;

   localparam int PTR_W = $clog2(TAPE_DEPTH);
   localparam int SA_W  = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
   localparam int LVL_W = $clog2(STACK_DEPTH + 1);

   // Tape pointer and a cached copy of the current cell. The RAM read port
   // always follows the pointer; after a write the cache holds the value.
   logic [PTR_W-1:0]      ptr_ff, ptr_in;
   logic [CELL_WIDTH-1:0] cell_ff, cell_in;
   logic                  cell_fresh_ff, cell_fresh_in;
   logic [CELL_WIDTH-1:0] tape_rdata;
   logic                  tape_we;
   logic [PTR_W-1:0]      tape_waddr;
   logic [CELL_WIDTH-1:0] tape_wdata;

   logic [PTR_W-1:0] clear_addr_ff, clear_addr_in;
   logic             clearing_ff, clearing_in;

   // Loop stack with the same caching scheme for its top entry.
   logic [LVL_W-1:0]          level_ff, level_in;
   logic [POSITION_WIDTH-1:0] top_ff, top_in;
   logic                      top_fresh_ff, top_fresh_in;
   logic [POSITION_WIDTH-1:0] stack_rdata;
   logic                      stack_we;
   logic [SA_W-1:0]           stack_raddr;

   logic                  skip_ff, skip_in;
   logic [SKIP_WIDTH-1:0] nest_ff, nest_in;

   logic                      valid_ff, valid_in;
   kind_type                  kind_ff, kind_in;
   logic [7:0]                char_ff, char_in;
   logic [POSITION_WIDTH-1:0] target_ff, target_in;

   logic                      take;
   logic                      cell_write;
   logic [CELL_WIDTH-1:0]     cur_cell;
   logic [POSITION_WIDTH-1:0] cur_top;
   logic                      cell_zero;

   assign take      = q_valid && !clearing_ff && (!valid_ff || !rsp_stall);
   assign cur_cell  = cell_fresh_ff ? tape_rdata : cell_ff;
   assign cur_top   = top_fresh_ff ? stack_rdata : top_ff;
   assign cell_zero = (cur_cell == '0);

   always_comb begin
      ptr_in        = ptr_ff;
      cell_in       = cell_ff;
      cell_fresh_in = cell_fresh_ff;
      cell_write    = 1'b0;
      level_in      = level_ff;
      top_in        = top_ff;
      top_fresh_in  = top_fresh_ff;
      stack_we      = 1'b0;
      skip_in       = skip_ff;
      nest_in       = nest_ff;
      kind_in       = KIND_NONE;
      char_in       = '0;
      target_in     = '0;

      if (take) begin
         if (skip_ff) begin
            // Pass over the loop body, tracking nested brackets.
            if (q_cmd == CMD_OPEN) begin
               if (nest_ff != '1) begin
                  nest_in = nest_ff + 1'b1;
               end
            end else if (q_cmd == CMD_CLOSE) begin
               if (nest_ff == '0) begin
                  skip_in = 1'b0;
               end else begin
                  nest_in = nest_ff - 1'b1;
               end
            end
         end else begin
            case (q_cmd)
               CMD_LEFT: begin
                  ptr_in = (ptr_ff == '0) ? PTR_W'(TAPE_DEPTH - 1) : ptr_ff - 1'b1;
                  cell_fresh_in = 1'b1;
               end
               CMD_RIGHT: begin
                  ptr_in = (ptr_ff == PTR_W'(TAPE_DEPTH - 1)) ? '0 : ptr_ff + 1'b1;
                  cell_fresh_in = 1'b1;
               end
               CMD_INC: begin
                  cell_in    = cur_cell + 1'b1;
                  cell_write = 1'b1;
               end
               CMD_DEC: begin
                  cell_in    = cur_cell - 1'b1;
                  cell_write = 1'b1;
               end
               CMD_IN: begin
                  cell_in    = q_value;
                  cell_write = 1'b1;
               end
               CMD_OPEN: begin
                  if (cell_zero) begin
                     skip_in = 1'b1;
                     nest_in = '0;
                  end else if (level_ff == LVL_W'(STACK_DEPTH)) begin
                     kind_in = KIND_ERROR;
                  end else begin
                     stack_we     = 1'b1;
                     level_in     = level_ff + 1'b1;
                     top_in       = q_pos;
                     top_fresh_in = 1'b0;
                  end
               end
               CMD_CLOSE: begin
                  if (level_ff == '0) begin
                     kind_in = KIND_ERROR;
                  end else if (!cell_zero) begin
                     kind_in   = KIND_JUMP;
                     target_in = cur_top;
                  end else begin
                     level_in     = level_ff - 1'b1;
                     top_fresh_in = 1'b1;
                  end
               end
               CMD_OUT: begin
                  if (cur_cell == '1) begin
                     kind_in = KIND_EOF;
                  end else begin
                     kind_in = KIND_CHAR;
                     char_in = cur_cell[7:0];
                  end
               end
               default: begin
               end
            endcase
            if (cell_write) begin
               cell_fresh_in = 1'b0;
            end
         end
      end

      if (take) begin
         valid_in = 1'b1;
      end else if (!rsp_stall) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end

      clearing_in   = clearing_ff && (clear_addr_ff != PTR_W'(TAPE_DEPTH - 1));
      clear_addr_in = clear_addr_ff + 1'b1;
   end

   assign tape_we     = clearing_ff || cell_write;
   assign tape_waddr  = clearing_ff ? clear_addr_ff : ptr_ff;
   assign tape_wdata  = clearing_ff ? '0 : cell_in;
   assign stack_raddr = SA_W'(level_in - 1'b1);

   bfie_ram #(
      .WIDTH (CELL_WIDTH),
      .DEPTH (TAPE_DEPTH)
   ) u_tape (
      .clock   (clock),
      .wr_en   (tape_we),
      .wr_addr (tape_waddr),
      .wr_data (tape_wdata),
      .rd_addr (ptr_in),
      .rd_data (tape_rdata)
   );

   bfie_ram #(
      .WIDTH (POSITION_WIDTH),
      .DEPTH (STACK_DEPTH)
   ) u_stack (
      .clock   (clock),
      .wr_en   (stack_we),
      .wr_addr (SA_W'(level_ff)),
      .wr_data (q_pos),
      .rd_addr (stack_raddr),
      .rd_data (stack_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         ptr_ff        <= '0;
         cell_ff       <= '0;
         cell_fresh_ff <= 1'b0;
         clearing_ff   <= 1'b1;
         clear_addr_ff <= '0;
         level_ff      <= '0;
         top_fresh_ff  <= 1'b0;
         skip_ff       <= 1'b0;
         nest_ff       <= '0;
         valid_ff      <= 1'b0;
      end else begin
         ptr_ff        <= ptr_in;
         cell_ff       <= cell_in;
         cell_fresh_ff <= cell_fresh_in;
         clearing_ff   <= clearing_in;
         clear_addr_ff <= clear_addr_in;
         level_ff      <= level_in;
         top_fresh_ff  <= top_fresh_in;
         skip_ff       <= skip_in;
         nest_ff       <= nest_in;
         valid_ff      <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      top_ff <= top_in;
      if (take) begin
         kind_ff   <= kind_in;
         char_ff   <= char_in;
         target_ff <= target_in;
      end
   end

   assign ctrl.pop      = take;
   assign ctrl.clearing = clearing_ff;

   assign rsp_valid       = valid_ff;
   assign rsp_kind        = kind_ff;
   assign rsp_out_char    = char_ff;
   assign rsp_jump_target = target_ff;

endmodule

`default_nettype wire

// File: hdl/brainfuck_instruction_executor_top.sv
// Top level of the Brainfuck instruction executor.
// Throughput: one command per cycle, sustained, while the result side keeps up.
// A transferred command is written into the decode queue and is executed straight
// out of it into the result register, which offers the result.
// After reset the tape is cleared one cell a cycle, all TAPE_DEPTH cells in turn,
// while req_stall stays high.
`default_nettype none

module brainfuck_instruction_executor_top #(
   parameter int TAPE_DEPTH     = 32768,
   parameter int STACK_DEPTH    = 64,
   parameter int POSITION_WIDTH = 16,
   parameter int CELL_WIDTH     = 32
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   output logic                           req_stall,
   input  wire logic [7:0]                req_op,
   input  wire logic [POSITION_WIDTH-1:0] req_next_position,
   input  wire logic [7:0]                req_in_byte,
   output logic                           rsp_valid,
   input  wire logic                      rsp_stall,
   output bfie_pkg::kind_type             rsp_kind,
   output logic [7:0]                     rsp_out_char,
   output logic [POSITION_WIDTH-1:0]      rsp_jump_target
);
   import bfie_pkg::*;

   back_ctrl_type             ctrl;
   logic                      q_valid;
   cmd_type                   q_cmd;
   logic [POSITION_WIDTH-1:0] q_pos;
   logic [CELL_WIDTH-1:0]     q_value;

   bfie_front #(
      .POSITION_WIDTH (POSITION_WIDTH),
      .CELL_WIDTH     (CELL_WIDTH)
   ) u_front (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_op            (req_op),
      .req_next_position (req_next_position),
      .req_in_byte       (req_in_byte),
      .ctrl              (ctrl),
      .q_valid           (q_valid),
      .q_cmd             (q_cmd),
      .q_pos             (q_pos),
      .q_value           (q_value)
   );

   bfie_back #(
      .TAPE_DEPTH     (TAPE_DEPTH),
      .STACK_DEPTH    (STACK_DEPTH),
      .POSITION_WIDTH (POSITION_WIDTH),
      .CELL_WIDTH     (CELL_WIDTH)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .q_valid         (q_valid),
      .q_cmd           (q_cmd),
      .q_pos           (q_pos),
      .q_value         (q_value),
      .ctrl            (ctrl),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_kind        (rsp_kind),
      .rsp_out_char    (rsp_out_char),
      .rsp_jump_target (rsp_jump_target)
   );

endmodule

`default_nettype wire

// File: hdl/bfie_checker.sv
// Port-level checker for the Brainfuck instruction executor, with its bind.
`default_nettype none

module bfie_checker #(
   parameter int POSITION_WIDTH = 16
) (
   input wire logic                      clock,
   input wire logic                      reset,
   input wire logic                      req_stall,
   input wire logic                      rsp_valid,
   input wire logic                      rsp_stall,
   input wire bfie_pkg::kind_type        rsp_kind,
   input wire logic [7:0]                rsp_out_char,
   input wire logic [POSITION_WIDTH-1:0] rsp_jump_target
);
   import bfie_pkg::*;

   // No result can come out of reset, and the tape clear blocks new commands.
   a_reset_quiet: assert property (@(posedge clock)
      $past(reset) |-> (!rsp_valid && req_stall))
      else $error("result offered or input open right after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> rsp_valid)
      else $error("result withdrawn while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=>
         ($stable(rsp_kind) && $stable(rsp_out_char) && $stable(rsp_jump_target)))
      else $error("stalled result changed");

   a_char_only: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_kind != KIND_CHAR) |-> (rsp_out_char == '0))
      else $error("character reported with a result that prints none");

   a_target_only: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_kind != KIND_JUMP) |-> (rsp_jump_target == '0))
      else $error("jump target reported with a result that is no jump");

endmodule

bind brainfuck_instruction_executor_top bfie_checker #(
   .POSITION_WIDTH (POSITION_WIDTH)
) u_bfie_checker (
   .clock           (clock),
   .reset           (reset),
   .req_stall       (req_stall),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_kind        (rsp_kind),
   .rsp_out_char    (rsp_out_char),
   .rsp_jump_target (rsp_jump_target)
);

`default_nettype wire

// File: test/tb.sv
// Self-checking testbench for the Brainfuck instruction executor top level.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import bfie_pkg::*;

   localparam int TAPE_DEPTH     = 32768;
   localparam int STACK_DEPTH    = 64;
   localparam int POSITION_WIDTH = 16;
   localparam int CELL_WIDTH     = 32;
   localparam int PTR_WIDTH      = $clog2(TAPE_DEPTH);
   localparam int RANDOM_ITEMS   = 1050;
   localparam int CYCLE_LIMIT    = 500000;
   localparam int PIPE_LATENCY   = 1;
   localparam int SKIP_NEST      = 40;

   typedef struct {
      kind_type                  kind;
      logic [7:0]                ch;
      logic [POSITION_WIDTH-1:0] target;
   } bf_result_type;

   logic                      clock;
   logic                      reset;
   logic                      req_valid;
   logic                      req_stall;
   logic [7:0]                req_op;
   logic [POSITION_WIDTH-1:0] req_next_position;
   logic [7:0]                req_in_byte;
   logic                      rsp_valid;
   logic                      rsp_stall = 1'b0;
   kind_type                  rsp_kind;
   logic [7:0]                rsp_out_char;
   logic [POSITION_WIDTH-1:0] rsp_jump_target;

   // Local copy of the machine state.
   logic [CELL_WIDTH-1:0]     tape_model [TAPE_DEPTH];
   logic [PTR_WIDTH-1:0]      cell_ptr;
   logic [POSITION_WIDTH-1:0] ret_stack_model [STACK_DEPTH];
   int                        loop_level;
   bit                        skipping;
   logic [SKIP_WIDTH-1:0]     skip_depth;

   bf_result_type pending_results[$];
   int            mismatches;
   int            cycle_count;
   bit            pace_gaps;
   int            burst_left;
   int            stall_pct;
   int            stall_hold;
   int            pct_hold;

   brainfuck_instruction_executor_top #(
      .TAPE_DEPTH    (TAPE_DEPTH),
      .STACK_DEPTH   (STACK_DEPTH),
      .POSITION_WIDTH(POSITION_WIDTH),
      .CELL_WIDTH    (CELL_WIDTH)
   ) dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_op           (req_op),
      .req_next_position(req_next_position),
      .req_in_byte      (req_in_byte),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_kind         (rsp_kind),
      .rsp_out_char     (rsp_out_char),
      .rsp_jump_target  (rsp_jump_target)
   );

   initial clock = 1'b0;
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic logic [POSITION_WIDTH-1:0] rand_pos();
      return POSITION_WIDTH'($urandom);
   endfunction

   function automatic logic [7:0] rand_byte();
      return 8'($urandom);
   endfunction

   function automatic bf_result_type execute_command(logic [7:0] op,
                                                     logic [POSITION_WIDTH-1:0] pos,
                                                     logic [7:0] in_b);
      bf_result_type         r;
      logic [CELL_WIDTH-1:0] cur_val;
      r.kind   = KIND_NONE;
      r.ch     = '0;
      r.target = '0;
      cur_val  = tape_model[cell_ptr];
      if (skipping) begin
         if (op == OP_OPEN) begin
            if (skip_depth != {SKIP_WIDTH{1'b1}}) skip_depth++;
         end else if (op == OP_CLOSE) begin
            if (skip_depth == 0) skipping = 1'b0;
            else skip_depth--;
         end
         return r;
      end
      case (op)
         OP_LEFT: begin
            cell_ptr = (cell_ptr == 0) ? PTR_WIDTH'(TAPE_DEPTH - 1) : cell_ptr - 1'b1;
         end
         OP_RIGHT: begin
            cell_ptr = (cell_ptr == PTR_WIDTH'(TAPE_DEPTH - 1)) ? '0 : cell_ptr + 1'b1;
         end
         OP_INC: tape_model[cell_ptr] = cur_val + 1'b1;
         OP_DEC: tape_model[cell_ptr] = cur_val - 1'b1;
         OP_OPEN: begin
            if (cur_val != 0) begin
               if (loop_level >= STACK_DEPTH) begin
                  r.kind = KIND_ERROR;
               end else begin
                  ret_stack_model[loop_level] = pos;
                  loop_level++;
               end
            end else begin
               skipping   = 1'b1;
               skip_depth = '0;
            end
         end
         OP_CLOSE: begin
            if (loop_level == 0) begin
               r.kind = KIND_ERROR;
            end else if (cur_val != 0) begin
               r.kind   = KIND_JUMP;
               r.target = ret_stack_model[loop_level - 1];
            end else begin
               loop_level--;
            end
         end
         OP_OUT: begin
            if (cur_val == {CELL_WIDTH{1'b1}}) begin
               r.kind = KIND_EOF;
            end else begin
               r.kind = KIND_CHAR;
               r.ch   = cur_val[7:0];
            end
         end
         OP_IN: begin
            if (in_b == TILDE_BYTE) tape_model[cell_ptr] = '1;
            else tape_model[cell_ptr] = {{(CELL_WIDTH-8){in_b[7]}}, in_b};
         end
         default: ;
      endcase
      return r;
   endfunction

   // Sends one command, holding it until the transfer, and records its result.
   task automatic send_command(input logic [7:0] op, input logic [POSITION_WIDTH-1:0] pos,
                               input logic [7:0] in_b, output bf_result_type res);
      if (pace_gaps && burst_left == 0) begin
         burst_left = ($urandom_range(0, 7) == 0) ? 200 : $urandom_range(1, 24);
         repeat ($urandom_range(1, 6)) begin
            @(negedge clock);
            req_valid = 1'b0;
         end
      end
      if (burst_left > 0) burst_left--;
      @(negedge clock);
      req_valid         = 1'b1;
      req_op            = op;
      req_next_position = pos;
      req_in_byte       = in_b;
      do @(posedge clock); while (req_stall);
      res = execute_command(op, pos, in_b);
      pending_results.push_back(res);
   endtask

   task automatic wait_results_drained();
      @(negedge clock);
      req_valid = 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   task automatic test_directed();
      bf_result_type res;
      send_command(OP_OUT, '0, 8'h00, res);
      send_command(OP_LEFT, rand_pos(), rand_byte(), res);   // pointer wraps to the top cell
      send_command(OP_IN, rand_pos(), TILDE_BYTE, res);
      send_command(OP_OUT, rand_pos(), rand_byte(), res);
      send_command(OP_INC, rand_pos(), rand_byte(), res);    // all ones wraps to zero
      send_command(OP_OUT, rand_pos(), rand_byte(), res);
      send_command(OP_DEC, rand_pos(), rand_byte(), res);
      send_command(OP_OUT, rand_pos(), rand_byte(), res);
      send_command(OP_RIGHT, rand_pos(), rand_byte(), res);  // and back to cell zero
      send_command(OP_IN, rand_pos(), 8'h80, res);
      send_command(OP_OUT, rand_pos(), rand_byte(), res);
      send_command(OP_IN, rand_pos(), 8'hFF, res);
      send_command(OP_OUT, rand_pos(), rand_byte(), res);
      send_command(OP_IN, rand_pos(), 8'h7F, res);
      send_command(OP_OUT, '1, rand_byte(), res);
      send_command(OP_CLOSE, rand_pos(), rand_byte(), res);  // empty stack, nonzero cell
      send_command(OP_OPEN, '1, rand_byte(), res);
      send_command(OP_CLOSE, rand_pos(), rand_byte(), res);
      send_command(OP_IN, rand_pos(), 8'h00, res);
      send_command(OP_CLOSE, rand_pos(), rand_byte(), res);
      send_command(OP_CLOSE, rand_pos(), rand_byte(), res);  // empty stack, zero cell
      send_command(OP_OPEN, rand_pos(), rand_byte(), res);   // zero cell starts a skip
      send_command(OP_OPEN, rand_pos(), rand_byte(), res);
      send_command(OP_INC, rand_pos(), rand_byte(), res);
      send_command(OP_CLOSE, rand_pos(), rand_byte(), res);
      send_command(OP_CLOSE, rand_pos(), rand_byte(), res);
      send_command(8'hFF, rand_pos(), rand_byte(), res);
      send_command(8'h00, rand_pos(), rand_byte(), res);
      send_command(OP_OUT, rand_pos(), rand_byte(), res);
   endtask

   task automatic test_stack_limits();
      bf_result_type res;
      send_command(OP_IN, rand_pos(), 8'h00, res);
      res.kind = KIND_NONE;
      while (res.kind != KIND_ERROR) send_command(OP_CLOSE, rand_pos(), rand_byte(), res);
      send_command(OP_IN, rand_pos(), 8'h01, res);
      repeat (STACK_DEPTH + 2) send_command(OP_OPEN, rand_pos(), rand_byte(), res);
      send_command(OP_CLOSE, rand_pos(), rand_byte(), res);
      // A zero cell on a full stack skips rather than overflowing.
      send_command(OP_IN, rand_pos(), 8'h00, res);
      send_command(OP_OPEN, rand_pos(), rand_byte(), res);
      send_command(OP_CLOSE, rand_pos(), rand_byte(), res);
      repeat (STACK_DEPTH + 1) send_command(OP_CLOSE, rand_pos(), rand_byte(), res);
      send_command(OP_IN, rand_pos(), 8'h05, res);
      send_command(OP_CLOSE, rand_pos(), rand_byte(), res);
   endtask

   task automatic test_skip_nesting();
      bf_result_type res;
      pace_gaps = 1'b0;
      send_command(OP_IN, rand_pos(), 8'h00, res);
      send_command(OP_OPEN, rand_pos(), rand_byte(), res);
      // A deep run of nested brackets is passed over as one loop body.
      repeat (SKIP_NEST) send_command(OP_OPEN, rand_pos(), rand_byte(), res);
      repeat (SKIP_NEST) send_command(OP_CLOSE, rand_pos(), rand_byte(), res);
      send_command(OP_OUT, rand_pos(), rand_byte(), res);
      send_command(OP_CLOSE, rand_pos(), rand_byte(), res);
      send_command(OP_INC, rand_pos(), rand_byte(), res);
      send_command(OP_OUT, rand_pos(), rand_byte(), res);
      pace_gaps = 1'b1;
   endtask

   // Small programs are run the way a fetcher would, following every jump; some rounds send random bytes.
   task automatic test_random_programs();
      logic [7:0]                prog [32];
      logic [POSITION_WIDTH-1:0] base;
      logic [POSITION_WIDTH-1:0] offset;
      logic [7:0]                in_b;
      bf_result_type             res;
      int                        len;
      int                        depth;
      int                        pc;
      int                        steps;
      int                        commands;
      bit                        drained;
      commands = 0;
      drained  = 1'b0;
      while (commands < RANDOM_ITEMS) begin
         if ($urandom_range(0, 4) == 0) begin
            repeat ($urandom_range(1, 6)) send_command(rand_byte(), rand_pos(), rand_byte(), res);
         end else begin
            len   = $urandom_range(6, 28);
            depth = 0;
            for (int i = 0; i < len; i++) begin
               case ($urandom_range(0, 9))
                  0: begin
                     if (depth < 3 && i < len - 2) begin
                        prog[i] = OP_OPEN;
                        depth++;
                     end else begin
                        prog[i] = OP_DEC;
                     end
                  end
                  1: begin
                     if (depth > 0) begin
                        prog[i] = OP_CLOSE;
                        depth--;
                     end else begin
                        prog[i] = OP_INC;
                     end
                  end
                  2: prog[i] = OP_INC;
                  3, 8: prog[i] = OP_DEC;
                  4: prog[i] = OP_LEFT;
                  5: prog[i] = OP_RIGHT;
                  6, 9: prog[i] = OP_OUT;
                  default: prog[i] = OP_IN;
               endcase
            end
            while (depth > 0) begin
               prog[len] = OP_CLOSE;
               len++;
               depth--;
            end
            if ($urandom_range(0, 9) == 0) begin
               prog[$urandom_range(0, len - 1)] = $urandom_range(0, 1) ? OP_OPEN : OP_CLOSE;
            end
            base  = rand_pos();
            pc    = 0;
            steps = 0;
            while (pc < len && steps < 120) begin
               if ($urandom_range(0, 7) == 0) in_b = TILDE_BYTE;
               else if ($urandom_range(0, 1) == 0) in_b = 8'($urandom_range(0, 3));
               else in_b = 8'($urandom_range(0, 255));
               send_command(prog[pc], base + POSITION_WIDTH'(pc + 1), in_b, res);
               steps++;
               commands++;
               if (res.kind == KIND_JUMP) begin
                  offset = res.target - base;
                  pc     = int'(offset);
               end else begin
                  pc++;
               end
            end
         end
         if (!drained && commands >= RANDOM_ITEMS / 2) begin
            wait_results_drained();
            drained = 1'b1;
         end
      end
   endtask

   // The receiver holds each stall level for a random run; the odds drift slowly.
   always @(negedge clock) begin
      if (pct_hold == 0) begin
         case ($urandom_range(0, 3))
            0: stall_pct = 0;
            1: stall_pct = 25;
            2: stall_pct = 50;
            default: stall_pct = 75;
         endcase
         pct_hold = $urandom_range(200, 2000);
      end else begin
         pct_hold--;
      end
      if (stall_hold == 0) begin
         rsp_stall  = ($urandom_range(0, 99) < stall_pct);
         stall_hold = rsp_stall ? $urandom_range(0, 5) : $urandom_range(0, 11);
      end else begin
         stall_hold--;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_results.size() == 0) begin
            $display("%0t: unexpected result, kind %0d char %0d target %0d", $time,
                     rsp_kind, rsp_out_char, rsp_jump_target);
            mismatches++;
         end else begin
            if (rsp_kind !== pending_results[0].kind) begin
               $display("%0t: kind expected %0d actual %0d", $time,
                        pending_results[0].kind, rsp_kind);
               mismatches++;
            end
            if (rsp_out_char !== pending_results[0].ch) begin
               $display("%0t: out_char expected %0d actual %0d", $time,
                        pending_results[0].ch, rsp_out_char);
               mismatches++;
            end
            if (rsp_jump_target !== pending_results[0].target) begin
               $display("%0t: jump_target expected %0d actual %0d", $time,
                        pending_results[0].target, rsp_jump_target);
               mismatches++;
            end
            void'(pending_results.pop_front());
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("** brainfuck_instruction_executor_top: FAILED **");
         $finish;
      end
   end

   initial begin
      reset             = 1'b1;
      req_valid         = 1'b0;
      req_op            = '0;
      req_next_position = '0;
      req_in_byte       = '0;
      pace_gaps         = 1'b1;
      burst_left        = 0;
      for (int i = 0; i < TAPE_DEPTH; i++) tape_model[i] = '0;
      for (int i = 0; i < STACK_DEPTH; i++) ret_stack_model[i] = '0;
      cell_ptr   = '0;
      loop_level = 0;
      skipping   = 1'b0;
      skip_depth = '0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_directed();
      test_stack_limits();
      test_skip_nesting();
      test_random_programs();

      wait_results_drained();
      repeat (PIPE_LATENCY + 16) @(posedge clock);
      if (mismatches == 0) begin
         $display("** brainfuck_instruction_executor_top: PASSED **");
      end else begin
         $display("** brainfuck_instruction_executor_top: FAILED **");
      end
      $finish;
   end
endmodule
